### rtl/core/smcd_pkg.sv
// Shared types and constants for the serial motor command decoder.
package smcd_pkg;

	localparam int unsigned POS_W = 6;

	typedef logic [7:0]       byte_t;
	typedef logic [POS_W-1:0] pos_t;

	typedef enum logic [1:0] {
		TUNE_NONE   = 2'd0,
		TUNE_FIRST  = 2'd1,
		TUNE_SECOND = 2'd2
	} tune_t;

	localparam byte_t NEWLINE_BYTE  = 8'h0a;
	localparam byte_t DUTY_AT_RESET = 8'h5f;
	localparam byte_t STEP_AT_RESET = 8'h11;

	localparam pos_t CMD_POS = pos_t'(2);
	localparam pos_t VAL_POS = pos_t'(4);

	// Command letters, lower case
	localparam byte_t CMD_DRIVE   = 8'h64; // d
	localparam byte_t CMD_STOP    = 8'h73; // s
	localparam byte_t CMD_REVERSE = 8'h72; // r
	localparam byte_t CMD_HIGHER  = 8'h68; // h
	localparam byte_t CMD_LOWER   = 8'h6c; // l
	localparam byte_t CMD_VALUE   = 8'h76; // v
	localparam byte_t CMD_TUNE1   = 8'h6d; // m
	localparam byte_t CMD_TUNE2   = 8'h61; // a

	localparam byte_t UPPER_FIRST = 8'h41; // A
	localparam byte_t UPPER_LAST  = 8'h5a; // Z
	localparam byte_t CASE_OFFSET = 8'h20;

	typedef struct packed {
		logic  line_end;
		logic  lamp_on;
		logic  drive_forward;
		logic  drive_reverse;
		byte_t pwm_duty;
		tune_t tune_start;
	} result_t;

	function automatic byte_t fold_case(input byte_t c);
		byte_t r;
		r = c;
		if (c >= UPPER_FIRST && c <= UPPER_LAST) begin
			r = c + CASE_OFFSET;
		end
		return r;
	endfunction

endpackage

### rtl/core/smcd_core.sv
// Line state, command execution and motor/lamp state registers.
module smcd_core #(
	parameter int unsigned LINE_LENGTH = 40
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  smcd_pkg::byte_t  rx_byte,
	input  smcd_pkg::byte_t  duty_step,
	output smcd_pkg::result_t result
);
	import smcd_pkg::*;

	localparam pos_t LineLen = pos_t'(LINE_LENGTH);

	pos_t  pos_q, pos_n;
	byte_t cmd_q, cmd_n;
	byte_t val_q, val_n;
	byte_t duty_q, duty_n;
	logic  fwd_q, fwd_n;
	logic  rev_q, rev_n;
	logic  lamp_q, lamp_n;
	tune_t tune;
	logic  ended;

	always_comb begin
		pos_n  = pos_q;
		cmd_n  = cmd_q;
		val_n  = val_q;
		duty_n = duty_q;
		fwd_n  = fwd_q;
		rev_n  = rev_q;
		lamp_n = lamp_q;
		tune   = TUNE_NONE;
		ended  = 1'b0;
		if (rx_byte == NEWLINE_BYTE) begin
			// A newline landing on a stored slot clears that slot first
			if (pos_q == CMD_POS) begin
				cmd_n = '0;
			end else if (pos_q == VAL_POS) begin
				val_n = '0;
			end
			case (fold_case(cmd_n))
				CMD_DRIVE: begin
					fwd_n = 1'b1;
					rev_n = 1'b0;
				end
				CMD_STOP: begin
					fwd_n = 1'b0;
					rev_n = 1'b0;
				end
				CMD_REVERSE: begin
					fwd_n = 1'b0;
					rev_n = 1'b1;
				end
				CMD_HIGHER: duty_n = duty_q + duty_step;
				CMD_LOWER: begin
					lamp_n = ~lamp_q;
					duty_n = duty_q - duty_step;
				end
				CMD_VALUE: duty_n = val_n;
				CMD_TUNE1: tune = TUNE_FIRST;
				CMD_TUNE2: tune = TUNE_SECOND;
				default: ;
			endcase
			pos_n = '0;
			ended = 1'b1;
		end else begin
			if (pos_q == CMD_POS) begin
				cmd_n = rx_byte;
			end else if (pos_q == VAL_POS) begin
				val_n = rx_byte;
			end
			// hold at the line length until the next newline
			if (pos_q < LineLen) begin
				pos_n = pos_q + pos_t'(1);
			end
		end
	end

	always_comb begin
		result.line_end      = ended;
		result.lamp_on       = lamp_n;
		result.drive_forward = fwd_n;
		result.drive_reverse = rev_n;
		result.pwm_duty      = duty_n;
		result.tune_start    = tune;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			cmd_q  <= '0;
			val_q  <= '0;
			duty_q <= DUTY_AT_RESET;
			fwd_q  <= 1'b1;
			rev_q  <= 1'b0;
			lamp_q <= 1'b1;
		end else if (advance) begin
			pos_q  <= pos_n;
			cmd_q  <= cmd_n;
			val_q  <= val_n;
			duty_q <= duty_n;
			fwd_q  <= fwd_n;
			rev_q  <= rev_n;
			lamp_q <= lamp_n;
		end
	end

endmodule

### rtl/core/serial_motor_command_decoder.sv
// Serial motor command decoder top level: input register, core, result register.
// Path: an accepted item is held in the input register, and its result is then captured
// in the result register when the output side is free.
// Throughput: one item per cycle; each stage advances whenever the stage after it drains.
// Reset: arst_n clears both stages, sets duty 95, forward on, reverse off, lamp on,
// duty_step 17, and clears the line position and stored command and value bytes.
module serial_motor_command_decoder #(
	parameter int unsigned LINE_LENGTH = 40
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  smcd_pkg::byte_t rx_byte,
	output logic            out_valid,
	input  logic            out_ready,
	output logic            line_end,
	output logic            lamp_on,
	output logic            drive_forward,
	output logic            drive_reverse,
	output smcd_pkg::byte_t pwm_duty,
	output logic [1:0]      tune_start,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  smcd_pkg::byte_t cfg_data
);
	import smcd_pkg::*;

	logic    valid_s1;
	byte_t   rx_byte_s1;
	logic    valid_s2;
	result_t res_s2;
	result_t res_next;
	byte_t   duty_step_q;
	logic    advance;

	assign advance   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_step_q <= STEP_AT_RESET;
		end else if (cfg_valid) begin
			duty_step_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	smcd_core #(
		.LINE_LENGTH(LINE_LENGTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.rx_byte  (rx_byte_s1),
		.duty_step(duty_step_q),
		.result   (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign out_valid     = valid_s2;
	assign line_end      = res_s2.line_end;
	assign lamp_on       = res_s2.lamp_on;
	assign drive_forward = res_s2.drive_forward;
	assign drive_reverse = res_s2.drive_reverse;
	assign pwm_duty      = res_s2.pwm_duty;
	assign tune_start    = res_s2.tune_start;

endmodule
